// ----- sv/grsr_pkg.sv -----
// Shared types, constants and register indexes of the glyph row span rasterizer.
package grsr_pkg;

    localparam int ROW_W                 = 8;
    localparam int COL_W                 = $clog2(ROW_W);
    localparam int COORD_W               = 16;
    localparam int DEF_MAX_GLYPH_WIDTH   = 8;
    localparam int DEF_MAX_GLYPH_HEIGHT  = 16;
    localparam int DEF_JOBQ_DEPTH        = 4;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 16;
    localparam int SETTLE_CYCLES         = 3;
    localparam int SETTLE_W              = $clog2(SETTLE_CYCLES + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_ADVANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_Y         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH   = 3'd7;

    localparam logic [1:0] ALIGN_CENTER = 2'd1;
    localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

    typedef struct packed {
        logic [3:0]         glyph_width;
        logic [4:0]         glyph_advance;
        logic [3:0]         scale;
        logic [COORD_W-1:0] anchor_x;
        logic [COORD_W-1:0] top_y;
        logic [15:0]        color;
        logic [1:0]         alignment;
        logic [7:0]         text_length;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] y;
        logic [ROW_W-1:0]   start_mask;
        logic [ROW_W-1:0]   end_mask;
    } job_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [6:0]         width;
        logic [3:0]         height;
        logic [15:0]        color;
        logic               last;
    } rect_t;

endpackage

// ----- sv/glyph_row_span_rasterizer_core.sv -----
// The front end takes a new glyph row every cycle while the request queue between the two
// halves has room and no register write is settling. The back end emits one rectangle per
// cycle while its result slot is free or being popped, so a row with k runs of set pixels
// yields k rectangles (at most four for an eight-column row); rows that draw nothing never
// reach it. The first rectangle of a row passes through the request queue, the current-row
// register and the output register before it shows at the result ports. After reset and
// after every register write, full stays high while the alignment products and the aligned start position settle.
module glyph_row_span_rasterizer_core
    import grsr_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
    parameter int JOBQ_DEPTH       = DEF_JOBQ_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [ROW_W-1:0]      row_bits,
    input  logic [3:0]            row_index,
    input  logic                  first_of_text,
    input  logic                  last_row_of_glyph,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [15:0]    rect_x,
    output logic signed [15:0]    rect_y,
    output logic [6:0]            rect_width,
    output logic [3:0]            rect_height,
    output logic [15:0]           rect_color,
    output logic                  last_of_row
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    job_t  push_job;
    job_t  head_job;
    rect_t rect;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GLYPH_WIDTH:   cfg_next.glyph_width   = cfg_data[3:0];
                CFG_GLYPH_ADVANCE: cfg_next.glyph_advance = cfg_data[4:0];
                CFG_SCALE:         cfg_next.scale         = cfg_data[3:0];
                CFG_ANCHOR_X:      cfg_next.anchor_x      = cfg_data;
                CFG_TOP_Y:         cfg_next.top_y         = cfg_data;
                CFG_COLOR:         cfg_next.color         = cfg_data;
                CFG_ALIGNMENT:     cfg_next.alignment     = cfg_data[1:0];
                CFG_TEXT_LENGTH:   cfg_next.text_length   = cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width   <= 4'd5;
            cfg_reg.glyph_advance <= 5'd6;
            cfg_reg.scale         <= 4'd1;
            cfg_reg.anchor_x      <= '0;
            cfg_reg.top_y         <= '0;
            cfg_reg.color         <= 16'hFFFF;
            cfg_reg.alignment     <= '0;
            cfg_reg.text_length   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    grsr_front #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .cfg_write         (cfg_write),
        .push              (push),
        .full              (full),
        .row_bits          (row_bits),
        .row_index         (row_index),
        .first_of_text     (first_of_text),
        .last_row_of_glyph (last_row_of_glyph),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_job             (push_job)
    );

    grsr_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (push_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty)
    );

    grsr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .rect    (rect)
    );

    assign rect_x      = $signed(rect.x);
    assign rect_y      = $signed(rect.y);
    assign rect_width  = rect.width;
    assign rect_height = rect.height;
    assign rect_color  = rect.color;
    assign last_of_row = rect.last;

`ifndef NO_ASSERTIONS
    a_settle_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_write) |-> full)
        else $error("input accepted while alignment settles");

    a_jobq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request queue overflow");

    a_jobq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("request queue underflow");

    a_rect_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rect_height == cfg_reg.scale && rect_width != 7'd0))
        else $error("rectangle with bad size");
`endif

endmodule

// ----- sv/grsr_front.sv -----
// Front end: cursor, alignment pipeline and run detection of each glyph row.
module grsr_front
    import grsr_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             cfg_write,
    input  logic             push,
    output logic             full,
    input  logic [ROW_W-1:0] row_bits,
    input  logic [3:0]       row_index,
    input  logic             first_of_text,
    input  logic             last_row_of_glyph,
    input  logic             q_full,
    output logic             q_push,
    output job_t             q_job
);

    logic [SETTLE_W-1:0]       settle_reg;
    logic [SETTLE_W-1:0]       settle_next;
    logic [COORD_W-1:0]        cursor_reg;
    logic [COORD_W-1:0]        cursor_next;
    logic [12:0]               len_adv_reg;
    logic [8:0]                step_reg;
    logic [16:0]               tws_reg;
    logic [COORD_W-1:0]        aligned_reg;
    logic [COORD_W-1:0]        aligned_next;
    logic signed [17:0]        tw;
    logic signed [17:0]        tw_adj;
    logic signed [17:0]        tw_half;
    logic                      accept;
    logic [COORD_W-1:0]        cursor_eff;
    logic [3:0]                gw;
    logic [ROW_W-1:0]          colv;
    logic [ROW_W-1:0]          smask;
    logic [ROW_W-1:0]          emask;
    logic [3:0]                src_idx;
    logic                      row_ok;

    // Alignment pipeline, refilled from the registers after every write
    always_comb
    begin
        if (cfg.scale != 4'd0 && cfg.text_length != 8'd0)
        begin
            tw = $signed({1'b0, tws_reg}) - $signed({14'd0, cfg.scale});
        end
        else
        begin
            tw = '0;
        end
        tw_adj  = tw + $signed({17'd0, tw[17]});
        tw_half = tw_adj >>> 1;
        unique case (cfg.alignment)
            ALIGN_CENTER: aligned_next = cfg.anchor_x - tw_half[COORD_W-1:0];
            ALIGN_RIGHT:  aligned_next = cfg.anchor_x - tw[COORD_W-1:0] + 16'd1;
            default:      aligned_next = cfg.anchor_x;
        endcase
    end

    always_ff @(posedge clk)
    begin
        len_adv_reg <= cfg.text_length * 13'(cfg.glyph_advance);
        step_reg    <= 9'(cfg.glyph_advance) * 9'(cfg.scale);
        tws_reg     <= 17'(len_adv_reg) * 17'(cfg.scale);
        aligned_reg <= aligned_next;
    end

    always_comb
    begin
        if (cfg_write)
        begin
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    assign full   = q_full || (settle_reg != '0);
    assign accept = push && !full;

    // Columns in display order, column 0 leftmost
    always_comb
    begin
        gw = (cfg.glyph_width > 4'(MAX_GLYPH_WIDTH)) ? 4'(MAX_GLYPH_WIDTH) : cfg.glyph_width;
        for (int c = 0; c < ROW_W; c++)
        begin
            src_idx = gw - 4'd1 - 4'(c);
            colv[c] = (4'(c) < gw) ? row_bits[src_idx[COL_W-1:0]] : 1'b0;
        end
        for (int c = 0; c < ROW_W; c++)
        begin
            smask[c] = colv[c] && ((c == 0) ? 1'b1 : !colv[(c == 0) ? 0 : c - 1]);
            emask[c] = colv[c] && ((c == ROW_W - 1) ? 1'b1 : !colv[(c == ROW_W - 1) ? c : c + 1]);
        end
    end

    assign cursor_eff = first_of_text ? aligned_reg : cursor_reg;
    assign row_ok     = (cfg.scale != 4'd0) && ({2'd0, row_index} < 6'(MAX_GLYPH_HEIGHT));

    always_comb
    begin
        cursor_next = cursor_reg;
        if (accept)
        begin
            cursor_next = last_row_of_glyph ? cursor_eff + 16'(step_reg) : cursor_eff;
        end
    end

    assign q_push           = accept && row_ok && (smask != '0);
    assign q_job.base_x     = cursor_eff;
    assign q_job.y          = cfg.top_y + 16'(8'(row_index) * 8'(cfg.scale));
    assign q_job.start_mask = smask;
    assign q_job.end_mask   = emask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
            cursor_reg <= '0;
        end
        else
        begin
            settle_reg <= settle_next;
            cursor_reg <= cursor_next;
        end
    end

endmodule

// ----- sv/grsr_jobq.sv -----
// Short request queue between the front end and the span emitter.
module grsr_jobq
    import grsr_pkg::*;
#(
    parameter int DEPTH = DEF_JOBQ_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output job_t rd_job,
    output logic q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/grsr_back.sv -----
// Back end: walk each row's runs, one scaled rectangle per unstalled cycle.
module grsr_back
    import grsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_empty,
    input  job_t  q_job,
    output logic  q_pop,
    output logic  empty,
    input  logic  pop,
    output rect_t rect
);

    logic             cur_valid_reg;
    logic             cur_valid_next;
    job_t             cur_reg;
    job_t             cur_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rect_t            out_reg;
    rect_t            out_next;
    logic             out_free;
    logic             emit;
    logic             done;
    logic [ROW_W-1:0] s_rest;
    logic [ROW_W-1:0] e_rest;
    logic [COL_W-1:0] s_col;
    logic [COL_W-1:0] e_col;
    logic [3:0]       run_len;

    function automatic logic [COL_W-1:0] lowest_set(input logic [ROW_W-1:0] m);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

    assign out_free = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && out_free;
    assign s_rest   = cur_reg.start_mask & (cur_reg.start_mask - 1'b1);
    assign e_rest   = cur_reg.end_mask & (cur_reg.end_mask - 1'b1);
    assign done     = emit && (s_rest == '0);
    assign q_pop    = !q_empty && (!cur_valid_reg || done);
    assign s_col    = lowest_set(cur_reg.start_mask);
    assign e_col    = lowest_set(cur_reg.end_mask);
    assign run_len  = 4'(e_col) - 4'(s_col) + 4'd1;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (q_pop)
        begin
            cur_next       = q_job;
            cur_valid_next = 1'b1;
        end
        else if (emit)
        begin
            cur_next.start_mask = s_rest;
            cur_next.end_mask   = e_rest;
            cur_valid_next      = !done;
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_next.x      = cur_reg.base_x + 16'(7'(s_col) * 7'(cfg.scale));
        out_next.y      = cur_reg.y;
        out_next.width  = 7'(8'(run_len) * 8'(cfg.scale));
        out_next.height = cfg.scale;
        out_next.color  = cfg.color;
        out_next.last   = (s_rest == '0);
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop || emit)
        begin
            cur_reg <= cur_next;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty = !out_valid_reg;
    assign rect  = out_reg;

endmodule
